// ===== hdl/bchj_pkg.sv =====
// shared types and constants for the bucket chain hash join core
`default_nettype none
package bchj_pkg;

  localparam int MAX_TUPLES_DEF   = 64;
  localparam int HASH_BUCKETS_DEF = 5;
  localparam int VALUE_W          = 32;
  localparam int ROW_W            = 32;

  localparam logic INDEX_ON_S_RESET = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_PROBE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row_id;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] key_r;
    logic [ROW_W-1:0] key_s;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/bchj_hash.sv =====
// bucket index unit: value mod HASH_BUCKETS by reciprocal multiplication, value then quotient registered
`default_nettype none
module bchj_hash #(
  parameter int HASH_BUCKETS = bchj_pkg::HASH_BUCKETS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [bchj_pkg::VALUE_W-1:0]      value,
  output logic                                   done,
  output logic [$clog2(HASH_BUCKETS)-1:0]        bucket
);
  import bchj_pkg::*;

  localparam int BKT_W   = $clog2(HASH_BUCKETS);
  localparam int SHIFT   = VALUE_W + BKT_W;
  localparam int PROD_W  = 2 * VALUE_W + 1;
  localparam int QUO_W   = PROD_W - SHIFT;
  localparam int RECIP_W = VALUE_W + 1;
  // ceil(2^SHIFT / HASH_BUCKETS) gives the exact quotient for every value
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(HASH_BUCKETS) - 64'd1) / 64'(HASH_BUCKETS));

  logic [VALUE_W-1:0] val_q;
  logic [QUO_W-1:0]   quo;
  logic               mul_busy;
  logic               sub_busy;

  assign done   = sub_busy;
  // remainder is below HASH_BUCKETS, so its low bits carry it whole
  assign bucket = BKT_W'(val_q - VALUE_W'(quo) * VALUE_W'(HASH_BUCKETS));

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      sub_busy <= 1'b0;
    end else begin
      mul_busy <= start;
      sub_busy <= mul_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_q <= value;
    end
    if (mul_busy) begin
      quo <= QUO_W'((PROD_W'(val_q) * PROD_W'(RECIP)) >> SHIFT);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bchj_bucket_mem.sv =====
// bucket table: head and tail pointers per bucket, with per-bucket valid flags
`default_nettype none
module bchj_bucket_mem #(
  parameter int HASH_BUCKETS = bchj_pkg::HASH_BUCKETS_DEF,
  parameter int PTR_W        = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clr,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(HASH_BUCKETS)-1:0] rd_addr,
  output logic                                 rd_hit,
  output logic [PTR_W-1:0]                     rd_head,
  output logic [PTR_W-1:0]                     rd_tail,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(HASH_BUCKETS)-1:0] wr_addr,
  input  wire logic [PTR_W-1:0]                wr_head,
  input  wire logic [PTR_W-1:0]                wr_tail
);
  import bchj_pkg::*;

  logic [PTR_W-1:0]        head_mem [HASH_BUCKETS];
  logic [PTR_W-1:0]        tail_mem [HASH_BUCKETS];
  logic [HASH_BUCKETS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_mem[wr_addr] <= wr_head;
      tail_mem[wr_addr] <= wr_tail;
    end
    if (rd_en) begin
      rd_head <= head_mem[rd_addr];
      rd_tail <= tail_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bchj_tuple_mem.sv =====
// tuple store: value, row id and next link per slot, one write and one read port
`default_nettype none
module bchj_tuple_mem #(
  parameter int MAX_TUPLES = bchj_pkg::MAX_TUPLES_DEF,
  parameter int SLOT_W     = 6,
  parameter int PTR_W      = 7
) (
  input  wire logic                         clk,
  input  wire logic                         wr_data_en,
  input  wire logic                         wr_link_en,
  input  wire logic [SLOT_W-1:0]            wr_addr,
  input  wire logic [bchj_pkg::VALUE_W-1:0] wr_value,
  input  wire logic [bchj_pkg::ROW_W-1:0]   wr_row,
  input  wire logic [PTR_W-1:0]             wr_link,
  input  wire logic                         rd_en,
  input  wire logic [SLOT_W-1:0]            rd_addr,
  output logic [bchj_pkg::VALUE_W-1:0]      rd_value,
  output logic [bchj_pkg::ROW_W-1:0]        rd_row,
  output logic [PTR_W-1:0]                  rd_link
);
  import bchj_pkg::*;

  logic [VALUE_W-1:0] value_mem [MAX_TUPLES];
  logic [ROW_W-1:0]   row_mem   [MAX_TUPLES];
  logic [PTR_W-1:0]   link_mem  [MAX_TUPLES];

  // link field has its own enable so a tail entry can be relinked alone
  always_ff @(posedge clk) begin
    if (wr_data_en) begin
      value_mem[wr_addr] <= wr_value;
      row_mem[wr_addr]   <= wr_row;
    end
    if (wr_link_en) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_row   <= row_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bucket_chain_hash_join_core.sv =====
// bucket chain hash join core: sequencer, output register and config
// clear is done on acceptance; build waits in S_HASH for the bucket index unit, reading the
// bucket table as it finishes, stores the tuple, then relinks the old tail of a nonempty chain
// probe reads the chain head, then walks one link per cycle in the tuple store read port, and
// sends the last beat; the walk and the last beat take longer while results are stalled
// reset clears the index (bucket valid flags, fill count) and sets index_on_s to 1
`default_nettype none
module bucket_chain_hash_join_core #(
  parameter int MAX_TUPLES   = bchj_pkg::MAX_TUPLES_DEF,
  parameter int HASH_BUCKETS = bchj_pkg::HASH_BUCKETS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire bchj_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output bchj_pkg::result_t      result,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data
);
  import bchj_pkg::*;

  localparam int PTR_W  = $clog2(MAX_TUPLES + 1);
  localparam int SLOT_W = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
  localparam int BKT_W  = $clog2(HASH_BUCKETS);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_HASH       = 6'b000010,
    S_BKT_RD     = 6'b000100,
    S_BUILD_LINK = 6'b001000,
    S_WALK       = 6'b010000,
    S_FLUSH      = 6'b100000
  } state_t;

  state_t           state;
  item_t            cur;
  logic [PTR_W-1:0] fill_count;
  logic [PTR_W-1:0] link_tail;
  logic [BKT_W-1:0] bkt;
  logic             index_on_s;
  result_t          pend;
  logic             pend_valid;

  logic             item_accept;
  logic             is_full;
  logic             hash_start;
  logic             hash_done;
  logic [BKT_W-1:0] hash_bucket;

  logic             bkt_hit;
  logic [PTR_W-1:0] bkt_head;
  logic [PTR_W-1:0] bkt_tail;
  logic             bkt_clr;
  logic             bkt_rd_en;
  logic             bkt_wr_en;
  logic [PTR_W-1:0] bkt_wr_head;

  logic             tup_wr_data_en;
  logic             tup_wr_link_en;
  logic [SLOT_W-1:0] tup_wr_addr;
  logic [PTR_W-1:0] tup_wr_link;
  logic             tup_rd_en;
  logic [SLOT_W-1:0] tup_rd_addr;
  logic [VALUE_W-1:0] tup_value;
  logic [ROW_W-1:0] tup_row;
  logic [PTR_W-1:0] tup_link;

  logic [PTR_W-1:0] new_ptr;
  logic [PTR_W-1:0] head_slot;
  logic [PTR_W-1:0] link_slot;
  logic [PTR_W-1:0] tail_slot;
  logic             is_build;
  logic             out_free;
  logic             walk_match;
  logic             walk_go;
  logic             push;
  result_t          match_pair;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign is_full     = (fill_count == PTR_W'(MAX_TUPLES));
  assign is_build    = (cur.kind == KIND_BUILD);
  assign new_ptr     = fill_count + PTR_W'(1);
  assign head_slot   = bkt_head - PTR_W'(1);
  assign link_slot   = tup_link - PTR_W'(1);
  assign tail_slot   = link_tail - PTR_W'(1);
  assign out_free    = !result_valid || !result_stall;

  assign hash_start = item_accept &&
                      ((item.kind == KIND_BUILD && !is_full) || item.kind == KIND_PROBE);

  // memory accesses are spaced by the sequencer, so a read never meets a
  // write to the same entry in one cycle
  assign bkt_clr     = item_accept && (item.kind == KIND_CLEAR);
  assign bkt_rd_en   = (state == S_HASH) && hash_done;
  assign bkt_wr_en   = (state == S_BKT_RD) && is_build;
  assign bkt_wr_head = bkt_hit ? bkt_head : new_ptr;

  always_comb begin
    tup_wr_data_en = 1'b0;
    tup_wr_link_en = 1'b0;
    tup_wr_addr    = fill_count[SLOT_W-1:0];
    tup_wr_link    = '0;
    if (state == S_BKT_RD && is_build) begin
      tup_wr_data_en = 1'b1;
      tup_wr_link_en = 1'b1;
    end else if (state == S_BUILD_LINK) begin
      tup_wr_link_en = 1'b1;
      tup_wr_addr    = tail_slot[SLOT_W-1:0];
      tup_wr_link    = fill_count;
    end
  end

  // a match waits in pend until the next match or the end of the chain,
  // which decides its last flag
  assign walk_match = (tup_value == cur.value);
  assign walk_go    = (state == S_WALK) && !(walk_match && pend_valid && !out_free);

  always_comb begin
    if (index_on_s) begin
      match_pair = '{key_r: cur.row_id, key_s: tup_row, last: 1'b0};
    end else begin
      match_pair = '{key_r: tup_row, key_s: cur.row_id, last: 1'b0};
    end
  end

  always_comb begin
    tup_rd_en   = 1'b0;
    tup_rd_addr = head_slot[SLOT_W-1:0];
    if (state == S_BKT_RD && cur.kind == KIND_PROBE && bkt_hit) begin
      tup_rd_en = 1'b1;
    end else if (walk_go && tup_link != '0) begin
      tup_rd_en   = 1'b1;
      tup_rd_addr = link_slot[SLOT_W-1:0];
    end
  end

  assign push = (walk_go && walk_match && pend_valid) ||
                ((state == S_FLUSH) && pend_valid && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      index_on_s   <= INDEX_ON_S_RESET;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        index_on_s <= cfg_wr_data;
      end
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_accept) begin
            case (item.kind)
              KIND_CLEAR: fill_count <= '0;
              KIND_BUILD: begin
                if (!is_full) begin
                  state <= S_HASH;
                end
              end
              KIND_PROBE: state <= S_HASH;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_BKT_RD;
          end
        end
        S_BKT_RD: begin
          if (is_build) begin
            fill_count <= new_ptr;
            state      <= bkt_hit ? S_BUILD_LINK : S_IDLE;
          end else begin
            state <= bkt_hit ? S_WALK : S_IDLE;
          end
        end
        S_BUILD_LINK: state <= S_IDLE;
        S_WALK: begin
          if (walk_go) begin
            if (walk_match) begin
              pend_valid <= 1'b1;
            end
            if (tup_link == '0) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      cur <= item;
    end
    if (hash_done) begin
      bkt <= hash_bucket;
    end
    if (state == S_BKT_RD) begin
      link_tail <= bkt_tail;
    end
    if (walk_go && walk_match) begin
      pend <= match_pair;
    end
    if (push) begin
      result <= '{key_r: pend.key_r, key_s: pend.key_s, last: (state == S_FLUSH)};
    end
  end

  bchj_hash #(
    .HASH_BUCKETS(HASH_BUCKETS)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .value (item.value),
    .done  (hash_done),
    .bucket(hash_bucket)
  );

  bchj_bucket_mem #(
    .HASH_BUCKETS(HASH_BUCKETS),
    .PTR_W       (PTR_W)
  ) u_bucket_mem (
    .clk    (clk),
    .rst    (rst),
    .clr    (bkt_clr),
    .rd_en  (bkt_rd_en),
    .rd_addr(hash_bucket),
    .rd_hit (bkt_hit),
    .rd_head(bkt_head),
    .rd_tail(bkt_tail),
    .wr_en  (bkt_wr_en),
    .wr_addr(bkt),
    .wr_head(bkt_wr_head),
    .wr_tail(new_ptr)
  );

  bchj_tuple_mem #(
    .MAX_TUPLES(MAX_TUPLES),
    .SLOT_W    (SLOT_W),
    .PTR_W     (PTR_W)
  ) u_tuple_mem (
    .clk       (clk),
    .wr_data_en(tup_wr_data_en),
    .wr_link_en(tup_wr_link_en),
    .wr_addr   (tup_wr_addr),
    .wr_value  (cur.value),
    .wr_row    (cur.row_id),
    .wr_link   (tup_wr_link),
    .rd_en     (tup_rd_en),
    .rd_addr   (tup_rd_addr),
    .rd_value  (tup_value),
    .rd_row    (tup_row),
    .rd_link   (tup_link)
  );

  // a new beat never lands on a stalled one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !(result_valid && result_stall))
    else $error("result beat overwritten while stalled");

  a_build_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_BKT_RD && is_build) |=> fill_count == $past(new_ptr))
    else $error("fill count not advanced by build");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    bkt_clr |=> fill_count == '0)
    else $error("clear left tuples in the index");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= PTR_W'(MAX_TUPLES))
    else $error("fill count beyond capacity");

endmodule
`default_nettype wire
